@@ sv/rhd_pkg.sv @@
// ----------------------------------------------------------------------------
// rhd_pkg
// Shared types and constants for the RTP HEVC depacketizer.
// ----------------------------------------------------------------------------
package rhd_pkg;

    localparam int MAX_PACKET_LEN = 65535;
    localparam logic [15:0] MAX_LEN_W = 16'(MAX_PACKET_LEN);

    localparam int MAX_RES   = 6;
    localparam int RES_SLOTS = MAX_RES + 1;
    localparam int QDEPTH    = 16;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int QCW       = $clog2(QDEPTH + 1);

    localparam logic [15:0] POS_MARKER = 16'd1;
    localparam logic [15:0] POS_SEQ_HI = 16'd2;
    localparam logic [15:0] POS_SEQ_LO = 16'd3;
    localparam logic [15:0] POS_PH0    = 16'd12;
    localparam logic [15:0] POS_PH1    = 16'd13;
    localparam logic [15:0] POS_SAT    = 16'hFFFF;

    localparam logic [5:0] NT_MAX_SINGLE = 6'd47;
    localparam logic [5:0] NT_AP         = 6'd48;
    localparam logic [5:0] NT_FU         = 6'd49;
    localparam logic [7:0] FU_HDR_MASK   = 8'h81;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_UNIT   = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        M_IDLE,
        M_SINGLE,
        M_FU_CTRL,
        M_FU_PASS,
        M_DROP,
        M_AP_HI,
        M_AP_LO,
        M_AP_DATA,
        M_PACI
    } mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       good;
        logic       last;
    } res_t;

endpackage

@@ sv/rhd_core.sv @@
// ----------------------------------------------------------------------------
// rhd_core
// Packet parser: header latch, sequence check, payload modes and the
// list of results caused by one item.
// ----------------------------------------------------------------------------
module rhd_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  rhd_pkg::item_t                      item,
    output rhd_pkg::res_t [rhd_pkg::RES_SLOTS-1:0] res,
    output logic [2:0]                          res_cnt
);

    logic [15:0]    expected_seq_reg, expected_seq_next;
    logic           seq_seen_reg, seq_seen_next;
    logic           unit_tainted_reg, unit_tainted_next;
    logic           unit_closed_reg, unit_closed_next;
    logic           inside_fragment_reg, inside_fragment_next;
    logic [15:0]    byte_position_reg, byte_position_next;
    logic [31:0]    header_latch_reg, header_latch_next;
    logic [16:0]    aggregate_remaining_reg, aggregate_remaining_next;
    rhd_pkg::mode_t mode_reg, mode_next;
    logic           pend_reg, pend_next;
    logic           pend_good_reg, pend_good_next;

    logic [7:0]     b;
    logic [15:0]    pos;
    logic [7:0]     b12;
    logic [5:0]     nal_type;
    logic [16:0]    agg_low;
    logic [16:0]    agg_dec;
    logic [7:0]     body [rhd_pkg::MAX_RES];
    logic [2:0]     body_cnt;
    logic           fin;
    rhd_pkg::res_t  fin_res;
    rhd_pkg::res_t  pend_res;
    logic [2:0]     total;
    logic [2:0]     idx;

    assign b        = item.data;
    assign pos      = byte_position_reg;
    assign b12      = header_latch_reg[7:0];
    assign nal_type = b12[6:1];
    assign agg_low  = aggregate_remaining_reg | {9'd0, b};
    assign agg_dec  = aggregate_remaining_reg - 17'd1;

    always_comb
    begin
        expected_seq_next        = expected_seq_reg;
        seq_seen_next            = seq_seen_reg;
        unit_tainted_next        = unit_tainted_reg;
        unit_closed_next         = unit_closed_reg;
        inside_fragment_next     = inside_fragment_reg;
        byte_position_next       = byte_position_reg;
        header_latch_next        = header_latch_reg;
        aggregate_remaining_next = aggregate_remaining_reg;
        mode_next                = mode_reg;
        for (int k = 0; k < rhd_pkg::MAX_RES; k++)
        begin
            body[k] = 8'd0;
        end
        body_cnt = 3'd0;
        fin      = 1'b0;
        fin_res  = '{data: 8'd0, kind: rhd_pkg::KIND_REJECT, good: 1'b0, last: 1'b0};

        if (pos >= rhd_pkg::MAX_LEN_W)
        begin
            unit_tainted_next = 1'b1;
        end
        else if (pos == rhd_pkg::POS_MARKER)
        begin
            header_latch_next[31:24] = b;
        end
        else if (pos == rhd_pkg::POS_SEQ_HI)
        begin
            header_latch_next[23:16] = b;
        end
        else if (pos == rhd_pkg::POS_SEQ_LO)
        begin
            header_latch_next[15:8] = b;
        end
        else if (pos == rhd_pkg::POS_PH0)
        begin
            header_latch_next[7:0] = b;
        end
        else if (pos == rhd_pkg::POS_PH1)
        begin
            if (unit_closed_reg)
            begin
                unit_tainted_next    = 1'b0;
                unit_closed_next     = 1'b0;
                inside_fragment_next = 1'b0;
            end
            if (seq_seen_reg && (header_latch_reg[23:8] != expected_seq_reg))
            begin
                unit_tainted_next = 1'b1;
            end
            expected_seq_next        = header_latch_reg[23:8] + 16'd1;
            seq_seen_next            = 1'b1;
            header_latch_next[15:8]  = b;
            if (nal_type <= rhd_pkg::NT_MAX_SINGLE)
            begin
                mode_next = rhd_pkg::M_SINGLE;
                body[3]   = 8'd1;
                body[4]   = b12;
                body[5]   = b;
                body_cnt  = 3'd6;
            end
            else if (nal_type == rhd_pkg::NT_FU)
            begin
                mode_next = rhd_pkg::M_FU_CTRL;
            end
            else if (nal_type == rhd_pkg::NT_AP)
            begin
                mode_next = rhd_pkg::M_AP_HI;
            end
            else
            begin
                mode_next = rhd_pkg::M_PACI;
            end
        end
        else if (pos > rhd_pkg::POS_PH1)
        begin
            case (mode_reg)
                rhd_pkg::M_SINGLE, rhd_pkg::M_FU_PASS:
                begin
                    body[0]  = b;
                    body_cnt = 3'd1;
                end
                rhd_pkg::M_FU_CTRL:
                begin
                    if (b[7])
                    begin
                        body[3]   = 8'd1;
                        body[4]   = (b12 & rhd_pkg::FU_HDR_MASK) | {1'b0, b[5:0], 1'b0};
                        body[5]   = header_latch_reg[15:8];
                        body_cnt  = 3'd6;
                        mode_next = rhd_pkg::M_FU_PASS;
                    end
                    else if (inside_fragment_reg)
                    begin
                        mode_next = rhd_pkg::M_FU_PASS;
                    end
                    else
                    begin
                        unit_tainted_next = 1'b1;
                        mode_next         = rhd_pkg::M_DROP;
                    end
                    inside_fragment_next = (b[7] || inside_fragment_reg) && !b[6];
                end
                rhd_pkg::M_AP_HI:
                begin
                    aggregate_remaining_next = {1'b0, b, 8'd0};
                    mode_next                = rhd_pkg::M_AP_LO;
                end
                rhd_pkg::M_AP_LO:
                begin
                    aggregate_remaining_next = agg_low;
                    if (agg_low == 17'd0)
                    begin
                        unit_tainted_next = 1'b1;
                        mode_next         = rhd_pkg::M_DROP;
                    end
                    else
                    begin
                        body[3]   = 8'd1;
                        body_cnt  = 3'd4;
                        mode_next = rhd_pkg::M_AP_DATA;
                    end
                end
                rhd_pkg::M_AP_DATA:
                begin
                    body[0]                  = b;
                    body_cnt                 = 3'd1;
                    aggregate_remaining_next = agg_dec;
                    if (agg_dec == 17'd0)
                    begin
                        mode_next = rhd_pkg::M_AP_HI;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (item.last)
        begin
            if ((pos < rhd_pkg::POS_PH1) || (mode_next == rhd_pkg::M_PACI) ||
                (mode_next == rhd_pkg::M_FU_CTRL))
            begin
                fin = 1'b1;
            end
            else
            begin
                if (mode_next == rhd_pkg::M_AP_DATA)
                begin
                    unit_tainted_next = 1'b1;
                end
                if (header_latch_next[31])
                begin
                    unit_closed_next = 1'b1;
                    fin              = 1'b1;
                    fin_res.kind     = rhd_pkg::KIND_UNIT;
                    fin_res.good     = !unit_tainted_next;
                end
            end
            mode_next          = rhd_pkg::M_IDLE;
            byte_position_next = 16'd0;
        end
        else if (pos < rhd_pkg::POS_SAT)
        begin
            byte_position_next = pos + 16'd1;
        end
    end

    assign pend_res = '{data: 8'd0, kind: rhd_pkg::KIND_UNIT, good: pend_good_reg, last: 1'b0};
    assign total    = {2'd0, pend_reg} + body_cnt + {2'd0, fin};
    assign res_cnt  = (total > 3'(rhd_pkg::MAX_RES)) ? 3'(rhd_pkg::MAX_RES) : total;

    always_comb
    begin
        pend_next      = pend_reg;
        pend_good_next = pend_good_reg;
        idx            = 3'd0;
        for (int k = 0; k < rhd_pkg::RES_SLOTS; k++)
        begin
            idx = 3'(k) - {2'd0, pend_reg};
            if (pend_reg && (k == 0))
            begin
                res[k] = pend_res;
            end
            else if (idx < body_cnt)
            begin
                res[k] = '{data: body[idx], kind: rhd_pkg::KIND_BYTE, good: 1'b0, last: 1'b0};
            end
            else if (fin && (idx == body_cnt))
            begin
                res[k] = fin_res;
            end
            else
            begin
                res[k] = '{data: 8'd0, kind: rhd_pkg::KIND_BYTE, good: 1'b0, last: 1'b0};
            end
            res[k].last = (3'(k) == (res_cnt - 3'd1));
        end
        if (advance)
        begin
            pend_next      = (total > 3'(rhd_pkg::MAX_RES));
            pend_good_next = fin_res.good;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_seq_reg        <= '0;
            seq_seen_reg            <= 1'b0;
            unit_tainted_reg        <= 1'b0;
            unit_closed_reg         <= 1'b0;
            inside_fragment_reg     <= 1'b0;
            byte_position_reg       <= '0;
            header_latch_reg        <= '0;
            aggregate_remaining_reg <= '0;
            mode_reg                <= rhd_pkg::M_IDLE;
            pend_reg                <= 1'b0;
            pend_good_reg           <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            pend_good_reg <= pend_good_next;
            if (advance)
            begin
                expected_seq_reg        <= expected_seq_next;
                seq_seen_reg            <= seq_seen_next;
                unit_tainted_reg        <= unit_tainted_next;
                unit_closed_reg         <= unit_closed_next;
                inside_fragment_reg     <= inside_fragment_next;
                byte_position_reg       <= byte_position_next;
                header_latch_reg        <= header_latch_next;
                aggregate_remaining_reg <= aggregate_remaining_next;
                mode_reg                <= mode_next;
            end
        end
    end

`ifndef SYNTH
    a_pend_at_packet_start: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (byte_position_reg == 16'd0))
        else $error("held completion outside packet start");

    a_idle_at_packet_start: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_position_reg == 16'd0) |-> (mode_reg == rhd_pkg::M_IDLE))
        else $error("payload mode left open across packets");
`endif

endmodule

@@ sv/rhd_queue.sv @@
// ----------------------------------------------------------------------------
// rhd_queue
// Result queue: takes up to six results per cycle, gives one per cycle.
// ----------------------------------------------------------------------------
module rhd_queue (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic [2:0]                             wr_cnt,
    input  rhd_pkg::res_t [rhd_pkg::RES_SLOTS-1:0] wr_data,
    input  logic                                   rd_en,
    output rhd_pkg::res_t                          rd_data,
    output logic [rhd_pkg::QCW-1:0]                count
);

    rhd_pkg::res_t                 mem [rhd_pkg::QDEPTH];
    logic [rhd_pkg::QAW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [rhd_pkg::QAW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [rhd_pkg::QCW-1:0]       count_reg, count_next;
    logic [2:0]                    wr_num;

    assign wr_num      = wr_en ? wr_cnt : 3'd0;
    assign wr_ptr_next = wr_ptr_reg + rhd_pkg::QAW'(wr_num);
    assign rd_ptr_next = rd_ptr_reg + rhd_pkg::QAW'(rd_en);
    assign count_next  = count_reg + rhd_pkg::QCW'(wr_num) - rhd_pkg::QCW'(rd_en);
    assign rd_data     = mem[rd_ptr_reg];
    assign count       = count_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < rhd_pkg::MAX_RES; k++)
        begin
            if (3'(k) < wr_num)
            begin
                mem[wr_ptr_reg + rhd_pkg::QAW'(k)] <= wr_data[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (({1'b0, count_reg} + 6'(wr_cnt)) <= 6'(rhd_pkg::QDEPTH)))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (count_reg != '0))
        else $error("result queue underflow");
`endif

endmodule

@@ sv/rtp_hevc_depacketizer.sv @@
// ----------------------------------------------------------------------------
// rtp_hevc_depacketizer
// RTP HEVC packet bytes in, Annex-B stream bytes and unit results out.
// ----------------------------------------------------------------------------
// Accepts one packet byte per cycle through an input register; the parser
// turns each byte into zero to six results and writes them into a 16-entry
// result queue, which delivers one result per cycle while m_tready is high.
// Input stalls only while the queue has fewer than six free entries, so long
// runs of start codes (single NAL and FU starts give six results for one
// byte) throttle intake to the one-result-per-cycle drain rate. An accepted
// byte passes through the input register and the result queue before its
// first result appears. A completion that would be a seventh result for one
// byte is held and delivered first with the next accepted byte.
module rtp_hevc_depacketizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser,   // [1:0] kind, [2] unit_good
    output logic       m_tlast
);

    logic                                   in_valid_reg;
    rhd_pkg::item_t                         in_item_reg;
    logic                                   advance;
    rhd_pkg::res_t [rhd_pkg::RES_SLOTS-1:0] res;
    logic [2:0]                             res_cnt;
    rhd_pkg::res_t                          head;
    logic [rhd_pkg::QCW-1:0]                q_count;
    logic                                   rd_en;

    assign advance  = in_valid_reg &&
                      (q_count <= rhd_pkg::QCW'(rhd_pkg::QDEPTH - rhd_pkg::MAX_RES));
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= '{data: s_tdata, last: s_tlast};
        end
    end

    rhd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .res     (res),
        .res_cnt (res_cnt)
    );

    rhd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (advance),
        .wr_cnt  (res_cnt),
        .wr_data (res),
        .rd_en   (rd_en),
        .rd_data (head),
        .count   (q_count)
    );

    assign m_tvalid = (q_count != '0);
    assign rd_en    = m_tvalid && m_tready;
    assign m_tdata  = head.data;
    assign m_tuser  = {head.good, head.kind};
    assign m_tlast  = head.last;

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |->
            (q_count > rhd_pkg::QCW'(rhd_pkg::QDEPTH - rhd_pkg::MAX_RES)))
        else $error("input stalled with queue space free");
`endif

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RTP HEVC depacketizer.
// ----------------------------------------------------------------------------
// Packets go in one byte per item. A directed packet table runs first: short
// packets, single NAL, FU start/middle/end and orphan fragments, aggregation
// packets with zero, cut-off and trailing sizes, PACI, sequence gaps and
// wrap, and crowded final bytes. Random packets follow, mostly well-formed
// with random content, plus broken ones and noise. A behavioral parser
// predicts every Annex-B byte, unit completion and reject. Both stream sides
// idle at random, with one long output stall.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEP_CAP  = rhd_pkg::MAX_RES + 2;
    localparam int LONG_HOLD = 400;
    localparam int N_ITEMS   = 500;

    typedef struct packed {
        logic           marker;
        logic [15:0]    seq;
        int             len;
        logic [7:0]     b12;
        logic [7:0]     b13;
        logic [47:0]    body;      // byte 14 in bits 47:40
        logic           typed;
        rhd_pkg::kind_t wkind;
        logic           wgood;
    } pkt_row_t;

    localparam int NDIR = 18;
    localparam pkt_row_t DIR_TAB [NDIR] = '{
        '{1'b0, 16'd0,    1,  8'h00, 8'h00, 48'h0,            1'b1, rhd_pkg::KIND_REJECT, 1'b0},
        '{1'b0, 16'd0,    13, 8'h02, 8'h00, 48'h0,            1'b1, rhd_pkg::KIND_REJECT, 1'b0},
        '{1'b1, 16'd0,    14, 8'h00, 8'h01, 48'h0,            1'b0, rhd_pkg::KIND_BYTE,   1'b0},
        '{1'b0, 16'd1,    20, 8'h5E, 8'hA5, 48'h0,            1'b0, rhd_pkg::KIND_BYTE,   1'b0},
        '{1'b1, 16'd2,    16, 8'hFF, 8'h00, 48'h0,            1'b1, rhd_pkg::KIND_REJECT, 1'b0},
        '{1'b0, 16'd3,    24, 8'h62, 8'h01, 48'h93_0000000000, 1'b0, rhd_pkg::KIND_BYTE,  1'b0},
        '{1'b0, 16'd4,    20, 8'h62, 8'h01, 48'h13_0000000000, 1'b0, rhd_pkg::KIND_BYTE,  1'b0},
        '{1'b1, 16'd5,    18, 8'h62, 8'h01, 48'h53_0000000000, 1'b1, rhd_pkg::KIND_UNIT,  1'b1},
        '{1'b1, 16'd6,    18, 8'h62, 8'h01, 48'h13_0000000000, 1'b1, rhd_pkg::KIND_UNIT,  1'b0},
        '{1'b0, 16'd7,    14, 8'h62, 8'h01, 48'h0,            1'b1, rhd_pkg::KIND_REJECT, 1'b0},
        '{1'b1, 16'd8,    15, 8'hE3, 8'hFF, 48'hFF_0000000000, 1'b0, rhd_pkg::KIND_BYTE,  1'b0},
        '{1'b1, 16'd100,  18, 8'h02, 8'h11, 48'h0,            1'b1, rhd_pkg::KIND_UNIT,   1'b0},
        '{1'b1, 16'd101,  21, 8'h60, 8'h01, 48'h0002AABB0001, 1'b0, rhd_pkg::KIND_BYTE,   1'b0},
        '{1'b1, 16'd102,  20, 8'h60, 8'h01, 48'h0000_12345678, 1'b1, rhd_pkg::KIND_UNIT,  1'b0},
        '{1'b1, 16'd103,  18, 8'h60, 8'h01, 48'h0010_0102_0000, 1'b1, rhd_pkg::KIND_UNIT, 1'b0},
        '{1'b1, 16'd104,  18, 8'h60, 8'h01, 48'h0001_5507_0000, 1'b0, rhd_pkg::KIND_BYTE, 1'b0},
        '{1'b0, 16'hFFFF, 20, 8'h5F, 8'hFF, 48'hFFFFFFFFFFFF, 1'b0, rhd_pkg::KIND_BYTE,   1'b0},
        '{1'b1, 16'h0000, 16, 8'h81, 8'h00, 48'h0,            1'b0, rhd_pkg::KIND_BYTE,   1'b0}
    };

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    rtp_hevc_depacketizer dut (.*);

    // parser state
    logic [15:0]    nx_seq;
    logic           seq_ok;
    logic           taint;
    logic           closed;
    logic           in_frag;
    logic [15:0]    pos_r;
    logic [31:0]    hdr;
    logic [16:0]    ap_left;
    rhd_pkg::mode_t pmode     = rhd_pkg::M_IDLE;
    logic           held;
    logic           held_good;

    rhd_pkg::res_t step_q [$];
    rhd_pkg::res_t stream_q [$];

    int  n_err, bytes_in, pkts_dir, pkts_rnd;
    int  n_stream, n_unit, n_bad_unit, n_reject, res_seen;
    int  hold_left;
    bit  long_done, src_calm, sink_calm, fu_open;
    logic [15:0] rnd_seq;

    initial
    begin
        nx_seq = '0; seq_ok = 1'b0; taint = 1'b0; closed = 1'b0; in_frag = 1'b0;
        pos_r = '0; hdr = '0; ap_left = '0; held = 1'b0; held_good = 1'b0;
    end

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void emit(input logic [7:0] d, input rhd_pkg::kind_t k,
                                 input logic g);
        if (step_q.size() < STEP_CAP)
            step_q.push_back('{data: d, kind: k, good: g, last: 1'b0});
    endfunction

    function automatic void emit_start_code();
        emit(8'h00, rhd_pkg::KIND_BYTE, 1'b0);
        emit(8'h00, rhd_pkg::KIND_BYTE, 1'b0);
        emit(8'h00, rhd_pkg::KIND_BYTE, 1'b0);
        emit(8'h01, rhd_pkg::KIND_BYTE, 1'b0);
    endfunction

    function automatic void begin_payload(input logic [7:0] b);
        logic [5:0]  t;
        logic [15:0] sq;
        t  = hdr[6:1];
        sq = hdr[23:8];
        if (closed)
        begin
            taint = 1'b0; closed = 1'b0; in_frag = 1'b0;
        end
        if (seq_ok && sq != nx_seq)
            taint = 1'b1;
        nx_seq = sq + 16'd1;
        seq_ok = 1'b1;
        hdr[15:8] = b;
        if (t <= rhd_pkg::NT_MAX_SINGLE)
        begin
            pmode = rhd_pkg::M_SINGLE;
            emit_start_code();
            emit(hdr[7:0], rhd_pkg::KIND_BYTE, 1'b0);
            emit(b, rhd_pkg::KIND_BYTE, 1'b0);
        end
        else if (t == rhd_pkg::NT_FU)
            pmode = rhd_pkg::M_FU_CTRL;
        else if (t == rhd_pkg::NT_AP)
            pmode = rhd_pkg::M_AP_HI;
        else
            pmode = rhd_pkg::M_PACI;
    endfunction

    function automatic void take_payload_byte(input logic [7:0] b);
        logic was;
        case (pmode)
            rhd_pkg::M_SINGLE, rhd_pkg::M_FU_PASS:
                emit(b, rhd_pkg::KIND_BYTE, 1'b0);
            rhd_pkg::M_FU_CTRL:
            begin
                was = in_frag;
                if (b[7])
                begin
                    emit_start_code();
                    emit((hdr[7:0] & rhd_pkg::FU_HDR_MASK) | {1'b0, b[5:0], 1'b0},
                         rhd_pkg::KIND_BYTE, 1'b0);
                    emit(hdr[15:8], rhd_pkg::KIND_BYTE, 1'b0);
                    pmode = rhd_pkg::M_FU_PASS;
                end
                else if (was)
                    pmode = rhd_pkg::M_FU_PASS;
                else
                begin
                    taint = 1'b1;
                    pmode = rhd_pkg::M_DROP;
                end
                in_frag = (b[7] || was) && !b[6];
            end
            rhd_pkg::M_AP_HI:
            begin
                ap_left = {1'b0, b, 8'h00};
                pmode = rhd_pkg::M_AP_LO;
            end
            rhd_pkg::M_AP_LO:
            begin
                ap_left = ap_left | 17'(b);
                if (ap_left == '0)
                begin
                    taint = 1'b1;
                    pmode = rhd_pkg::M_DROP;
                end
                else
                begin
                    emit_start_code();
                    pmode = rhd_pkg::M_AP_DATA;
                end
            end
            rhd_pkg::M_AP_DATA:
            begin
                emit(b, rhd_pkg::KIND_BYTE, 1'b0);
                ap_left = ap_left - 17'd1;
                if (ap_left == '0)
                    pmode = rhd_pkg::M_AP_HI;
            end
            default: ;
        endcase
    endfunction

    // fill step_q with the results of one packet byte
    function automatic void parse_rtp_byte(input logic [7:0] b, input logic last);
        logic [15:0] p;
        step_q.delete();
        if (held)
        begin
            emit(8'h00, rhd_pkg::KIND_UNIT, held_good);
            held = 1'b0;
        end
        p = pos_r;
        if (p >= rhd_pkg::MAX_LEN_W)
            taint = 1'b1;
        else if (p == rhd_pkg::POS_MARKER)
            hdr[31:24] = b;
        else if (p == rhd_pkg::POS_SEQ_HI)
            hdr[23:16] = b;
        else if (p == rhd_pkg::POS_SEQ_LO)
            hdr[15:8] = b;
        else if (p == rhd_pkg::POS_PH0)
            hdr[7:0] = b;
        else if (p == rhd_pkg::POS_PH1)
            begin_payload(b);
        else if (p > rhd_pkg::POS_PH1)
            take_payload_byte(b);

        if (last)
        begin
            if (p < rhd_pkg::POS_PH1 || pmode == rhd_pkg::M_PACI ||
                pmode == rhd_pkg::M_FU_CTRL)
                emit(8'h00, rhd_pkg::KIND_REJECT, 1'b0);
            else
            begin
                if (pmode == rhd_pkg::M_AP_DATA)
                    taint = 1'b1;
                if (hdr[31])
                begin
                    closed = 1'b1;
                    emit(8'h00, rhd_pkg::KIND_UNIT, !taint);
                end
            end
            pmode = rhd_pkg::M_IDLE;
            pos_r = '0;
        end
        else if (p != rhd_pkg::POS_SAT)
            pos_r = p + 16'd1;

        if (step_q.size() > rhd_pkg::MAX_RES)
        begin
            held = 1'b1;
            held_good = step_q[rhd_pkg::MAX_RES].good;
            while (step_q.size() > rhd_pkg::MAX_RES)
                void'(step_q.pop_back());
        end
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
    endfunction

    function automatic int idle_len(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic l, input logic typed,
                             input rhd_pkg::kind_t wk, input logic wg);
        int gap;
        gap = idle_len(src_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        do @(posedge clk); while (!s_tready);
        bytes_in++;
        parse_rtp_byte(d, l);
        if (typed)
        begin
            if (step_q.size() > 0)
                void'(step_q.pop_back());
            step_q.push_back('{data: 8'h00, kind: wk, good: wg, last: 1'b1});
        end
        foreach (step_q[i])
            stream_q.push_back(step_q[i]);
    endtask

    task automatic send_packet(ref logic [7:0] pk[$], input logic typed,
                               input rhd_pkg::kind_t wk, input logic wg);
        foreach (pk[i])
            send_byte(pk[i], i == pk.size() - 1, typed && (i == pk.size() - 1), wk, wg);
    endtask

    function automatic void put_rtp_header(ref logic [7:0] pk[$], input logic mk,
                                           input logic [15:0] sq);
        pk.push_back(8'h80);
        pk.push_back({mk, 7'd96});
        pk.push_back(sq[15:8]);
        pk.push_back(sq[7:0]);
        repeat (8) pk.push_back(8'($urandom));
    endfunction

    function automatic void put_random(ref logic [7:0] pk[$], input int n);
        repeat (n) pk.push_back(8'($urandom));
    endfunction

    task automatic send_table_row(input pkt_row_t row);
        logic [7:0] pk [$];
        put_rtp_header(pk, row.marker, row.seq);
        pk.push_back(row.b12);
        pk.push_back(row.b13);
        for (int i = 0; i < 6; i++)
            pk.push_back(row.body[47 - 8 * i -: 8]);
        while (pk.size() < row.len)
            pk.push_back(8'($urandom));
        while (pk.size() > row.len)
            void'(pk.pop_back());
        send_packet(pk, row.typed, row.wkind, row.wgood);
        pkts_dir++;
    endtask

    task automatic send_random_packet();
        logic [7:0] pk [$];
        int         sel, nn, sz;
        logic       mk, st, en;
        logic [5:0] t;
        sel = $urandom_range(0, 99);
        mk  = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 19) == 0)
            rnd_seq = 16'($urandom);
        if ($urandom_range(0, 9) == 0)
            src_calm = !src_calm;
        if (sel < 5)
            put_random(pk, $urandom_range(1, 24));
        else if (sel < 10)
            put_random(pk, $urandom_range(1, 13));
        else
        begin
            put_rtp_header(pk, mk, rnd_seq);
            rnd_seq = rnd_seq + 16'd1;
            if (sel < 45)
            begin
                t = 6'($urandom_range(0, int'(rhd_pkg::NT_MAX_SINGLE)));
                pk.push_back({$urandom_range(0, 7) == 0, t, 1'($urandom)});
                put_random(pk, 1 + $urandom_range(0, 6));
            end
            else if (sel < 72)
            begin
                pk.push_back({$urandom_range(0, 7) == 0, rhd_pkg::NT_FU, 1'($urandom)});
                pk.push_back(8'($urandom));
                if ($urandom_range(0, 19) != 0)
                begin
                    if ($urandom_range(0, 9) == 0)
                        pk.push_back(8'($urandom));
                    else
                    begin
                        st = !fu_open;
                        en = fu_open ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 4) == 0);
                        pk.push_back({st, en, 6'($urandom)});
                    end
                    fu_open = (pk[14][7] || fu_open) && !pk[14][6];
                    put_random(pk, $urandom_range(0, 5));
                end
            end
            else if (sel < 90)
            begin
                pk.push_back({$urandom_range(0, 7) == 0, rhd_pkg::NT_AP, 1'($urandom)});
                pk.push_back(8'($urandom));
                nn = $urandom_range(1, 2);
                repeat (nn)
                begin
                    sz = $urandom_range(1, 3);
                    pk.push_back(8'h00);
                    pk.push_back(8'(sz));
                    put_random(pk, sz);
                end
                case ($urandom_range(0, 7))
                    0: put_random(pk, 1);
                    1:
                    begin
                        pk.push_back(8'h00);
                        pk.push_back(8'h00);
                        put_random(pk, $urandom_range(0, 3));
                    end
                    2:
                    begin
                        pk.push_back(8'($urandom_range(1, 255)));
                        put_random(pk, $urandom_range(1, 4));
                    end
                    default: ;
                endcase
            end
            else
            begin
                t = 6'($urandom_range(int'(rhd_pkg::NT_FU) + 1, 63));
                pk.push_back({1'($urandom), t, 1'($urandom)});
                put_random(pk, 1 + $urandom_range(0, 6));
            end
            if (mk)
                fu_open = 1'b0;
        end
        send_packet(pk, 1'b0, rhd_pkg::KIND_BYTE, 1'b0);
        pkts_rnd++;
    endtask

    // output side: check each item, then pick the next ready
    always @(posedge clk)
    begin
        rhd_pkg::res_t got, e;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{data: m_tdata, kind: rhd_pkg::kind_t'(m_tuser[1:0]),
                        good: m_tuser[2], last: m_tlast};
                res_seen++;
                case (got.kind)
                    rhd_pkg::KIND_BYTE: n_stream++;
                    rhd_pkg::KIND_UNIT:
                    begin
                        n_unit++;
                        if (!got.good)
                            n_bad_unit++;
                    end
                    default:            n_reject++;
                endcase
                if (stream_q.size() == 0)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("%0t: unexpected item data=%h kind=%0d good=%b last=%b",
                                 $realtime, got.data, got.kind, got.good, got.last);
                end
                else
                begin
                    e = stream_q.pop_front();
                    if (got.data !== e.data || got.kind !== e.kind ||
                        got.good !== e.good || got.last !== e.last)
                    begin
                        n_err++;
                        if (n_err <= 10)
                            $display("%0t: mismatch exp data=%h kind=%0d good=%b last=%b, %s",
                                     $realtime, e.data, e.kind, e.good, e.last,
                                     $sformatf("got data=%h kind=%0d good=%b last=%b",
                                               got.data, got.kind, got.good, got.last));
                    end
                end
            end
            if ($urandom_range(0, 299) == 0)
                sink_calm = !sink_calm;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!long_done && res_seen >= 60)
            begin
                long_done = 1'b1;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end
            else
            begin
                hold_left = idle_len(sink_calm);
                m_tready <= (hold_left == 0);
                if (hold_left > 0)
                    hold_left--;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_TAB[i])
            send_table_row(DIR_TAB[i]);

        // hold input until the output is drained
        s_tvalid <= 1'b0;
        do @(posedge clk); while (stream_q.size() != 0);

        rnd_seq = 16'd2;
        while (bytes_in < N_ITEMS)
            send_random_packet();

        s_tvalid <= 1'b0;
        do @(posedge clk); while (stream_q.size() != 0);
        repeat (20) @(posedge clk);

        $display("Covered %0d packets (%0d table, %0d random), %0d bytes in total",
                 pkts_dir + pkts_rnd, pkts_dir, pkts_rnd, bytes_in);
        $display("Checked %0d stream bytes, %0d unit ends (%0d bad), %0d rejects, %0d errors",
                 n_stream, n_unit, n_bad_unit, n_reject, n_err);
        if (n_err == 0 && stream_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d items outstanding", stream_q.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
